@@ hdl/crrm_pkg.sv @@
// crrm_pkg: request and result types and operation codes for the contiguous ring
// region manager. Has no dependencies; the step logic and the top level use it.
`timescale 1ns / 1ps

package crrm_pkg;

    localparam int FIELD_W  = 16;
    localparam int OPCODE_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [OPCODE_W-1:0] OP_WR_ACQ = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_REL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RD_ACQ = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RD_REL = 2'd3;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 5'd16;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FIELD_W-1:0]  count;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] write_space;
        logic [FIELD_W-1:0] read_available;
    } rsp_t;

endpackage

@@ hdl/crrm_step.sv @@
// crrm_step: combinational next-state and result logic for one descriptor request.
// Depends on crrm_pkg for the request and result types and the operation codes.
`timescale 1ns / 1ps

module crrm_step #(
    parameter int MAX_SIZE_LOG2 = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic [crrm_pkg::CFG_W-1:0] size_log2,
    input  crrm_pkg::req_t             req,
    input  logic [POSITION_BITS-1:0]   wr_pos,
    input  logic [POSITION_BITS-1:0]   rd_pos,
    input  logic [POSITION_BITS-1:0]   gap_pos,
    input  logic [MAX_SIZE_LOG2:0]     gap_len,
    input  logic [MAX_SIZE_LOG2:0]     pend_len,
    output logic [POSITION_BITS-1:0]   wr_pos_next,
    output logic [POSITION_BITS-1:0]   rd_pos_next,
    output logic [POSITION_BITS-1:0]   gap_pos_next,
    output logic [MAX_SIZE_LOG2:0]     gap_len_next,
    output logic [MAX_SIZE_LOG2:0]     pend_len_next,
    output crrm_pkg::rsp_t             rsp
);

    localparam int GW = MAX_SIZE_LOG2 + 1;
    localparam int AW = ((POSITION_BITS > GW) ? POSITION_BITS : GW) + 2;
    localparam int PW = POSITION_BITS;
    localparam logic [AW-1:0] SAT_MAX = AW'(16'hFFFF);

    function automatic logic [PW-1:0] pos_dist(input logic [PW-1:0] pos,
                                               input logic [PW-1:0] base);
        return pos - base;
    endfunction

    logic [crrm_pkg::CFG_W-1:0] eff_log2;
    logic [AW-1:0] ring_size;
    logic [AW-1:0] rmask;
    logic [AW-1:0] used;
    logic [AW-1:0] space;
    logic [AW-1:0] cnt;
    logic [AW-1:0] wr_ofs;
    logic [AW-1:0] wr_linear;
    logic [AW-1:0] rel_sum;
    logic [AW-1:0] wr_adv;
    logic          at_gap;
    logic [PW-1:0] rd_skip;
    logic [GW-1:0] gap_len_skip;
    logic [AW-1:0] used_skip;
    logic [AW-1:0] dg_skip;
    logic [AW-1:0] avail_skip;
    logic [AW-1:0] rd_ofs;
    logic [AW-1:0] rd_linear;
    logic [AW-1:0] dg_now;
    logic [AW-1:0] rd_limit;
    logic [AW-1:0] rd_take;
    logic          granted;
    logic [AW-1:0] offset;
    logic [AW-1:0] length;
    logic [AW-1:0] used_f;
    logic [AW-1:0] space_f;
    logic [AW-1:0] dg_f;
    logic [AW-1:0] avail_f;

    // effective size is clamped to 1..MAX_SIZE_LOG2
    always_comb
    begin
        if (size_log2 == '0)
            eff_log2 = crrm_pkg::CFG_W'(1);
        else if (size_log2 > crrm_pkg::CFG_W'(MAX_SIZE_LOG2))
            eff_log2 = crrm_pkg::CFG_W'(MAX_SIZE_LOG2);
        else
            eff_log2 = size_log2;
    end

    assign ring_size = AW'(1) << eff_log2;
    assign rmask     = ring_size - AW'(1);
    assign used      = AW'(pos_dist(wr_pos, rd_pos));
    assign space     = (used < ring_size) ? ring_size - used - AW'(1) : '0;
    assign cnt       = AW'(req.count);
    assign wr_ofs    = AW'(wr_pos) & rmask;
    assign wr_linear = ring_size - wr_ofs;

    // write release: a pending wrap gap is committed together with the data
    assign rel_sum = (pend_len != '0) ? AW'(pend_len) + cnt : cnt;
    assign wr_adv  = (rel_sum > space) ? space : rel_sum;

    // read acquire: step over a finished wrap gap first
    assign at_gap       = (gap_len != '0) && (rd_pos == gap_pos);
    assign rd_skip      = at_gap ? rd_pos + PW'(gap_len) : rd_pos;
    assign gap_len_skip = at_gap ? '0 : gap_len;
    assign used_skip    = AW'(pos_dist(wr_pos, rd_skip));
    assign dg_skip      = AW'(pos_dist(gap_pos, rd_skip));
    assign avail_skip   = (gap_len_skip != '0 && dg_skip != '0 && dg_skip <= used_skip)
                          ? dg_skip : used_skip;
    assign rd_ofs       = AW'(rd_skip) & rmask;
    assign rd_linear    = ring_size - rd_ofs;

    // read release: never consume past an active gap or the written data
    assign dg_now   = AW'(pos_dist(gap_pos, rd_pos));
    assign rd_limit = (gap_len != '0 && dg_now <= used) ? dg_now : used;
    assign rd_take  = (cnt > rd_limit) ? rd_limit : cnt;

    always_comb
    begin
        wr_pos_next   = wr_pos;
        rd_pos_next   = rd_pos;
        gap_pos_next  = gap_pos;
        gap_len_next  = gap_len;
        pend_len_next = pend_len;
        granted       = 1'b1;
        offset        = '0;
        length        = '0;
        unique case (req.opcode)
            crrm_pkg::OP_WR_ACQ:
            begin
                granted = 1'b0;
                if (!(cnt >= ring_size || cnt > space))
                begin
                    pend_len_next = '0;
                    if (cnt > wr_linear)
                    begin
                        // wrap to offset zero, the tail becomes a gap
                        if (gap_len == '0 && cnt + wr_linear <= space)
                        begin
                            pend_len_next = GW'(wr_linear);
                            granted       = 1'b1;
                        end
                    end
                    else
                    begin
                        granted = 1'b1;
                        offset  = wr_ofs;
                    end
                end
            end
            crrm_pkg::OP_WR_REL:
            begin
                if (pend_len != '0)
                begin
                    gap_pos_next  = wr_pos;
                    gap_len_next  = pend_len;
                    pend_len_next = '0;
                end
                wr_pos_next = wr_pos + PW'(wr_adv);
            end
            crrm_pkg::OP_RD_ACQ:
            begin
                granted = 1'b0;
                if (!(at_gap && used < AW'(gap_len)))
                begin
                    rd_pos_next  = rd_skip;
                    gap_len_next = gap_len_skip;
                    if (avail_skip != '0)
                    begin
                        granted = 1'b1;
                        offset  = rd_ofs;
                        length  = (avail_skip < rd_linear) ? avail_skip : rd_linear;
                    end
                end
            end
            crrm_pkg::OP_RD_REL:
            begin
                rd_pos_next = rd_pos + PW'(rd_take);
            end
        endcase
    end

    // status after the step
    assign used_f  = AW'(pos_dist(wr_pos_next, rd_pos_next));
    assign space_f = (used_f < ring_size) ? ring_size - used_f - AW'(1) : '0;
    assign dg_f    = AW'(pos_dist(gap_pos_next, rd_pos_next));

    always_comb
    begin
        avail_f = used_f;
        if (gap_len_next != '0 && dg_f == '0 && used_f >= AW'(gap_len_next))
            avail_f = used_f - AW'(gap_len_next);
        else if (gap_len_next != '0 && dg_f != '0 && dg_f <= used_f
                 && used_f - dg_f >= AW'(gap_len_next))
            avail_f = used_f - AW'(gap_len_next);
    end

    assign rsp.granted        = granted;
    assign rsp.offset         = offset[crrm_pkg::FIELD_W-1:0];
    assign rsp.length         = length[crrm_pkg::FIELD_W-1:0];
    assign rsp.write_space    = (space_f > SAT_MAX) ? 16'hFFFF
                                                    : space_f[crrm_pkg::FIELD_W-1:0];
    assign rsp.read_available = (avail_f > SAT_MAX) ? 16'hFFFF
                                                    : avail_f[crrm_pkg::FIELD_W-1:0];

endmodule

@@ hdl/contiguous_ring_region_manager.sv @@
// contiguous_ring_region_manager: descriptor bookkeeping for a contiguous byte ring.
// A request is captured in the request register; its result is registered once the
// result register is free. Throughput: one request per cycle while out_ready is high,
// set by the single-pass step logic between the two registers. Reset (rst_n low,
// asynchronous) empties the ring and sets size_log2 to 16; a configuration write
// also empties the ring. Depends on crrm_pkg and crrm_step.
`timescale 1ns / 1ps

module contiguous_ring_region_manager #(
    parameter int MAX_SIZE_LOG2 = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [crrm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  crrm_pkg::req_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output crrm_pkg::rsp_t             out_data
);

    localparam int GW = MAX_SIZE_LOG2 + 1;
    localparam int PW = POSITION_BITS;

    logic [crrm_pkg::CFG_W-1:0] size_log2_reg;
    logic [PW-1:0]              wr_pos_reg, wr_pos_next;
    logic [PW-1:0]              rd_pos_reg, rd_pos_next;
    logic [PW-1:0]              gap_pos_reg, gap_pos_next;
    logic [GW-1:0]              gap_len_reg, gap_len_next;
    logic [GW-1:0]              pend_len_reg, pend_len_next;
    logic                       in_vld_reg, in_vld_next;
    logic                       out_vld_reg, out_vld_next;
    crrm_pkg::req_t             req_reg;
    crrm_pkg::rsp_t             rsp_reg, rsp_next;
    logic                       in_fire;
    logic                       step_go;

    // a held request executes once the result register is free
    assign step_go  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step_go;
    assign in_fire  = in_valid && in_ready;

    assign in_vld_next  = in_fire ? 1'b1 : (step_go ? 1'b0 : in_vld_reg);
    assign out_vld_next = step_go ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    crrm_step #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .size_log2     (size_log2_reg),
        .req           (req_reg),
        .wr_pos        (wr_pos_reg),
        .rd_pos        (rd_pos_reg),
        .gap_pos       (gap_pos_reg),
        .gap_len       (gap_len_reg),
        .pend_len      (pend_len_reg),
        .wr_pos_next   (wr_pos_next),
        .rd_pos_next   (rd_pos_next),
        .gap_pos_next  (gap_pos_next),
        .gap_len_next  (gap_len_next),
        .pend_len_next (pend_len_next),
        .rsp           (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= crrm_pkg::SIZE_LOG2_RESET;
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            gap_pos_reg   <= '0;
            gap_len_reg   <= '0;
            pend_len_reg  <= '0;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
            begin
                // new size restarts the ring empty
                size_log2_reg <= cfg_wr_data;
                wr_pos_reg    <= '0;
                rd_pos_reg    <= '0;
                gap_pos_reg   <= '0;
                gap_len_reg   <= '0;
                pend_len_reg  <= '0;
            end
            else if (step_go)
            begin
                wr_pos_reg   <= wr_pos_next;
                rd_pos_reg   <= rd_pos_next;
                gap_pos_reg  <= gap_pos_next;
                gap_len_reg  <= gap_len_next;
                pend_len_reg <= pend_len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            req_reg <= in_data;
        if (step_go)
            rsp_reg <= rsp_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = rsp_reg;

    // a wrap is only pending while no gap is active
    a_pend_excl_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_len_reg != '0) |-> (gap_len_reg == '0))
        else $error("pending wrap gap while a gap is active");

    // the write position never runs a full ring ahead of the read position
    a_used_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        (PW'(wr_pos_reg - rd_pos_reg) < (PW + GW)'(1) << size_log2_reg)
        || (size_log2_reg == '0))
        else $error("ring occupancy reached ring size");

    // a configuration write leaves the ring empty
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (wr_pos_reg == '0 && rd_pos_reg == '0
                       && gap_len_reg == '0 && pend_len_reg == '0))
        else $error("ring not cleared by configuration write");

endmodule
